// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with a synchronous clock and an
// active-low reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/gyd_pkg.sv -----
// ----------------------------------------------------------------------------
// gyd_pkg
// Widths, register reset values, register indexes, sequencer states and the
// control bundle of the yaw delta reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package gyd_pkg;

  // Field and datapath widths
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned BIAS_W     = 24;
  localparam int unsigned DB_W       = 24;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned THR_W      = 51;
  localparam int unsigned OUT_W      = 52;
  localparam int unsigned RATE_W     = 26;
  localparam int unsigned DIFF_W     = 27;
  localparam int unsigned FACC_W     = 37;  // 28-bit high half, 9-bit alpha shift half
  localparam int unsigned FHI_W      = 28;
  localparam int unsigned PROD_W     = 59;  // 27-bit high half, 32-bit elapsed shift half
  localparam int unsigned PHI_W      = 27;
  localparam int unsigned RND_W      = 38;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 51;
  localparam int unsigned CNT_W      = 5;

  // Last step index of the two bit-serial multiplies
  localparam logic [CNT_W-1:0] FILT_LAST = CNT_W'(ALPHA_W - 1);
  localparam logic [CNT_W-1:0] MULT_LAST = CNT_W'(TS_W - 1);

  // Full-weight alpha (new sample only)
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // Rounding offset of the filter, half an LSB of the Q8 result
  localparam logic signed [RND_W-1:0] RND_HALF = 38'sd128;

  // Register reset values
  localparam logic [BIAS_W-1:0]  BIAS_RST     = 24'd0;
  localparam logic [DB_W-1:0]    DEADBAND_RST = 24'd11738;
  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd64;
  localparam logic [THR_W-1:0]   SEND_RST     = 51'd6707200000;
  localparam logic [TS_W-1:0]    SILENCE_RST  = 32'd200000;
  localparam logic [THR_W-1:0]   RESIDUE_RST  = 51'd33536000;
  localparam logic [TS_W-1:0]    MAX_STEP_RST = 32'd100000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS     = 3'd0,
    CFG_INVERT   = 3'd1,
    CFG_DEADBAND = 3'd2,
    CFG_ALPHA    = 3'd3,
    CFG_SEND_THR = 3'd4,
    CFG_SILENCE  = 3'd5,
    CFG_RESIDUE  = 3'd6,
    CFG_MAX_STEP = 3'd7
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RATE,
    ST_DIFF,
    ST_FILT,
    ST_ROUND,
    ST_DEAD,
    ST_MULT,
    ST_ACCUM,
    ST_DECIDE,
    ST_REPORT
  } gyd_state_e;

  // Datapath strobes from the sequencer
  typedef struct packed {
    logic take;       // ready for a new request
    logic check;      // elapsed time and start-up handling
    logic rate;       // bias removal and sign
    logic diff;       // filter difference, load alpha shifter
    logic filt_step;  // one bit of alpha * difference
    logic round;      // filter output with rounding
    logic dead;       // deadband, load elapsed shifter
    logic mult_step;  // one bit of rate * elapsed
    logic accum;      // saturating add to the pending delta
    logic decide;     // report conditions
    logic report_ld;  // load the output register
  } gyd_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/gyro_yaw_delta_reporter_top.sv -----
// ----------------------------------------------------------------------------
// gyro_yaw_delta_reporter_top
// Low-pass filtered, deadbanded yaw rate integrated over sample time, reported
// as a saturated delta on threshold or after a silence period.
// ----------------------------------------------------------------------------
// Sequence: a kept sample runs the 9-step bit-serial filter multiply and the
//   32-step rate * elapsed multiply; the first sample and skipped samples
//   return to idle after the check. A new request is taken only in idle.
// Reset: asynchronous, clears control and persistent state and loads register
//   defaults; the working and output payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gyro_yaw_delta_reporter_top
  import gyd_pkg::*;
#(
  parameter int unsigned ACCUM_BITS = 52
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // configuration writes
  input  wire                           cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]         cfg_data_i,
  // sample requests
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  signed [RAW_W-1:0]       gyro_raw_i,
  input  wire  [TS_W-1:0]               timestamp_us_i,
  // report requests
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [OUT_W-1:0]       yaw_delta_o,
  output logic                          report_cause_o
);

  localparam int unsigned SUM_W = ((ACCUM_BITS > PROD_W) ? ACCUM_BITS : PROD_W) + 1;
  localparam int unsigned CMP_W = (ACCUM_BITS > THR_W) ? ACCUM_BITS : THR_W;
  localparam int unsigned EXT_W = (ACCUM_BITS > OUT_W) ? ACCUM_BITS : OUT_W;

  // Saturation bounds of the accumulator, at the sum width
  localparam logic [SUM_W-1:0] AMAX_U =
    {{(SUM_W - ACCUM_BITS + 1){1'b0}}, {(ACCUM_BITS - 1){1'b1}}};
  localparam logic [SUM_W-1:0] AMIN_U = ~AMAX_U;

  // Configuration registers
  logic signed [BIAS_W-1:0] bias_q;
  logic                     invert_q;
  logic [DB_W-1:0]          deadband_q;
  logic [ALPHA_W-1:0]       alpha_q;
  logic [THR_W-1:0]         send_thr_q;
  logic [TS_W-1:0]          silence_q;
  logic [THR_W-1:0]         residue_q;
  logic [TS_W-1:0]          max_step_q;

  // Sequencer
  gyd_state_e               state_q, state_d;
  gyd_ctl_t                 ctl;
  logic [CNT_W-1:0]         cnt_q;

  // Persistent state
  logic                     started_q;
  logic [TS_W-1:0]          last_sample_q;
  logic [TS_W-1:0]          last_report_q;
  logic signed [RATE_W-1:0] filt_q;
  logic signed [ACCUM_BITS-1:0] pending_q;

  // Per-sample working registers
  logic signed [RAW_W-1:0]  raw_q;
  logic [TS_W-1:0]          now_q;
  logic [TS_W-1:0]          elapsed_q;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [FACC_W-1:0] facc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     enough_q;

  // Output register
  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  yaw_q;
  logic                     cause_q;

  // Combinational datapath
  logic [TS_W-1:0]          elapsed_w;
  logic                     skip_w;
  logic signed [RATE_W-1:0] scaled_w;
  logic signed [RATE_W-1:0] corr_w;
  logic signed [RATE_W-1:0] rate_w;
  logic [ALPHA_W-1:0]       alpha_eff;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [FHI_W-1:0]  fsum_w;
  logic signed [RND_W-1:0]  rnd_w;
  logic [RATE_W-1:0]        filt_abs;
  logic signed [PHI_W-1:0]  psum_w;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [ACCUM_BITS-1:0] sat_w;
  logic [ACCUM_BITS-1:0]    acc_abs;
  logic                     enough_w;
  logic                     silent_w;
  logic [TS_W-1:0]          since_w;
  logic signed [EXT_W-1:0]  acc_ext;
  logic                     out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q     <= BIAS_RST;
      invert_q   <= 1'b0;
      deadband_q <= DEADBAND_RST;
      alpha_q    <= ALPHA_RST;
      send_thr_q <= SEND_RST;
      silence_q  <= SILENCE_RST;
      residue_q  <= RESIDUE_RST;
      max_step_q <= MAX_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BIAS:     bias_q     <= cfg_data_i[BIAS_W-1:0];
        CFG_INVERT:   invert_q   <= cfg_data_i[0];
        CFG_DEADBAND: deadband_q <= cfg_data_i[DB_W-1:0];
        CFG_ALPHA:    alpha_q    <= cfg_data_i[ALPHA_W-1:0];
        CFG_SEND_THR: send_thr_q <= cfg_data_i[THR_W-1:0];
        CFG_SILENCE:  silence_q  <= cfg_data_i[TS_W-1:0];
        CFG_RESIDUE:  residue_q  <= cfg_data_i[THR_W-1:0];
        CFG_MAX_STEP: max_step_q <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Elapsed time and skip test
  assign elapsed_w = now_q - last_sample_q;
  assign skip_w    = (elapsed_w == '0) || (elapsed_w > max_step_q);

  // Bias-corrected rate in Q8, optionally negated
  assign scaled_w = {{(RATE_W - RAW_W - 8){raw_q[RAW_W-1]}}, raw_q, 8'h00};
  assign corr_w   = scaled_w - RATE_W'(bias_q);
  assign rate_w   = invert_q ? -corr_w : corr_w;

  // Filter: new = old + alpha * (rate - old) / 256, alpha clamped to 256
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign diff_w    = DIFF_W'(rate_q) - DIFF_W'(filt_q);

  // One multiplier bit of alpha * diff: add into the high half, shift right
  assign fsum_w = facc_q[FACC_W-1:ALPHA_W]
                + (facc_q[0] ? FHI_W'(diff_q) : FHI_W'(0));

  // 256 * old + alpha * diff + half, then floor divide by 256
  assign rnd_w = (RND_W'(filt_q) <<< 8) + RND_W'(facc_q) + RND_HALF;

  assign filt_abs = filt_q[RATE_W-1] ? RATE_W'(-filt_q) : RATE_W'(filt_q);

  // One multiplier bit of rate * elapsed
  assign psum_w = prod_q[PROD_W-1:TS_W]
                + (prod_q[0] ? PHI_W'(filt_q) : PHI_W'(0));

  // Saturating accumulate
  assign sum_w = SUM_W'(pending_q) + SUM_W'(prod_q);
  always_comb begin
    if (sum_w > $signed(AMAX_U)) begin
      sat_w = ACCUM_BITS'(AMAX_U);
    end else if (sum_w < $signed(AMIN_U)) begin
      sat_w = ACCUM_BITS'(AMIN_U);
    end else begin
      sat_w = ACCUM_BITS'(sum_w);
    end
  end

  // Report conditions
  assign acc_abs  = pending_q[ACCUM_BITS-1] ? (~pending_q + 1'b1) : pending_q;
  assign since_w  = now_q - last_report_q;
  assign enough_w = CMP_W'(acc_abs) >= CMP_W'(send_thr_q);
  assign silent_w = (since_w >= silence_q) && (CMP_W'(acc_abs) > CMP_W'(residue_q));

  assign acc_ext  = EXT_W'(pending_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (!started_q || skip_w) ? ST_IDLE : ST_RATE;
      ST_RATE:   state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_FILT;
      ST_FILT:   if (cnt_q == FILT_LAST) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_DEAD;
      ST_DEAD:   state_d = ST_MULT;
      ST_MULT:   if (cnt_q == MULT_LAST) state_d = ST_ACCUM;
      ST_ACCUM:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = (enough_w || silent_w) ? ST_REPORT : ST_IDLE;
      ST_REPORT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    case (state_q)
      ST_IDLE:   ctl.take      = 1'b1;
      ST_CHECK:  ctl.check     = 1'b1;
      ST_RATE:   ctl.rate      = 1'b1;
      ST_DIFF:   ctl.diff      = 1'b1;
      ST_FILT:   ctl.filt_step = 1'b1;
      ST_ROUND:  ctl.round     = 1'b1;
      ST_DEAD:   ctl.dead      = 1'b1;
      ST_MULT:   ctl.mult_step = 1'b1;
      ST_ACCUM:  ctl.accum     = 1'b1;
      ST_DECIDE: ctl.decide    = 1'b1;
      ST_REPORT: ctl.report_ld = out_free;
      default:   ctl = '0;
    endcase
  end

  assign in_stall_o = !ctl.take;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      started_q     <= 1'b0;
      last_sample_q <= '0;
      last_report_q <= '0;
      filt_q        <= '0;
      pending_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // step counter for both serial multiplies
      if (ctl.diff || ctl.dead) begin
        cnt_q <= '0;
      end else if (ctl.filt_step || ctl.mult_step) begin
        cnt_q <= cnt_q + 1'b1;
      end

      // first sample records both times; later ones move the sample time
      if (ctl.check) begin
        started_q     <= 1'b1;
        last_sample_q <= now_q;
        if (!started_q) begin
          last_report_q <= now_q;
        end
      end

      if (ctl.round) begin
        filt_q <= rnd_w[RATE_W+7:8];
      end else if (ctl.dead && (filt_abs < RATE_W'(deadband_q))) begin
        filt_q <= '0;
      end

      if (ctl.accum) begin
        pending_q <= sat_w;
      end else if (ctl.report_ld) begin
        pending_q <= '0;
      end

      if (ctl.report_ld) begin
        last_report_q <= now_q;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    if (ctl.take && in_valid_i) begin
      raw_q <= gyro_raw_i;
      now_q <= timestamp_us_i;
    end
    if (ctl.check) begin
      elapsed_q <= elapsed_w;
    end
    if (ctl.rate) begin
      rate_q <= rate_w;
    end
    if (ctl.diff) begin
      diff_q <= diff_w;
      facc_q <= {{(FACC_W - ALPHA_W){1'b0}}, alpha_eff};
    end else if (ctl.filt_step) begin
      facc_q <= {fsum_w[FHI_W-1], fsum_w, facc_q[ALPHA_W-1:1]};
    end
    if (ctl.dead) begin
      prod_q <= {{(PROD_W - TS_W){1'b0}}, elapsed_q};
    end else if (ctl.mult_step) begin
      prod_q <= {psum_w[PHI_W-1], psum_w, prod_q[TS_W-1:1]};
    end
    if (ctl.decide) begin
      enough_q <= enough_w;
    end
    if (ctl.report_ld) begin
      yaw_q   <= acc_ext[OUT_W-1:0];
      cause_q <= !enough_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign yaw_delta_o    = yaw_q;
  assign report_cause_o = cause_q;

  // Checks
  `ASSERT_HOLDS(a_load_from_report, clk_i, rst_ni,
    !$rose(out_valid_o) || $past(state_q == ST_REPORT), "result loaded outside report")
  `ASSERT_NEXT(a_mult_runs_out, clk_i, rst_ni,
    (state_q == ST_MULT) && (cnt_q != MULT_LAST), state_q == ST_MULT, "multiply cut short")
  `ASSERT_NEXT(a_report_clears, clk_i, rst_ni,
    ctl.report_ld, (pending_q == '0) && out_valid_o, "report did not clear the delta")
  `ASSERT_HOLDS(a_deadband_applied, clk_i, rst_ni,
    (state_q != ST_MULT) || (filt_q == '0) || (filt_abs >= RATE_W'(deadband_q)),
    "rate inside deadband reached the integrator")

endmodule

`default_nettype wire
